// ===== rtl/rhr_pkg.sv =====
package rhr_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_ANGLE    = 3'd0;
  localparam logic [2:0] ST_FALLBACK = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_DONE     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // CORDIC arithmetic: angles in 2^-32 turn, datapath wide enough for growth.
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 36;
  localparam int STEP_BITS    = 5;

  typedef logic [CW-1:0] cw_t;

  // Arctangent table, atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051D;
      5'd2:  t = 32'h09FB385B; 5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53; 5'd9:  t = 32'h00145F2E;
      5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2F9; 5'd15: t = 32'h0000517C;
      5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517;
      5'd20: t = 32'h0000028B; 5'd21: t = 32'h00000145;
      5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // Request and reply between the controller and the CORDIC unit.
  typedef struct packed {
    logic go;
    cw_t  x;
    cw_t  y;
  } rhr_cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] z;
  } rhr_cordic_rsp_t;

endpackage

// ===== rtl/right_hand_rule_neighbor_select.sv =====
// Channel | Ports                         | Handshake
// input   | in_op .. in_prev_y            | start high while busy low
// result  | out_next_hop/best_angle/status | out_valid one cycle, no stall
// A write reads and checks each entry in turn, then updates the table in
// S_WR_DONE before its result; a remove skips that update step.
// A query first runs one CORDIC for the previous hop, then per entry reads
// and checks it, waiting for a CORDIC run if the entry is angled.
// Reset clears the valid flags; the table memory itself is not cleared.
// The result cannot be held off; busy stays high until it is shown.
module right_hand_rule_neighbor_select #(
  parameter int TABLE_DEPTH = 16,
  parameter int COORD_BITS  = 24,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_neighbor_addr,
  input  logic signed [COORD_BITS-1:0] in_neighbor_x,
  input  logic signed [COORD_BITS-1:0] in_neighbor_y,
  input  logic signed [COORD_BITS-1:0] in_self_x,
  input  logic signed [COORD_BITS-1:0] in_self_y,
  input  logic signed [COORD_BITS-1:0] in_prev_x,
  input  logic signed [COORD_BITS-1:0] in_prev_y,
  output logic                         out_valid,
  output logic [31:0]                  out_next_hop,
  output logic [ANGLE_BITS-1:0]        out_best_angle,
  output logic [2:0]                   out_status
);
  import rhr_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CT = IW + 1;
  localparam int EW = 32 + 2 * COORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_WR_DONE, S_PREV_WAIT,
    S_Q_RD, S_Q_CHK, S_Q_WAIT, S_FINISH
  } state_t;

  state_t state_r;

  // Entry memory, address and position, with a registered read.
  logic [EW-1:0]     mem [TABLE_DEPTH];
  logic [EW-1:0]     rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [TABLE_DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Latched transaction.
  logic [1:0]            op_r;
  logic [31:0]           addr_r;
  logic [COORD_BITS-1:0] nx_r, ny_r, sx_r, sy_r;
  logic [CT-1:0]         idx_r;
  logic                  hit_r, free_r;
  logic [IW-1:0]         hit_slot_r, free_slot_r;
  logic [31:0]           pref_r, low_r, best_addr_r;
  logic [ANGLE_BITS:0]   best_r;
  logic                  any_r, found_r, prev_ok_r;
  logic [IW-1:0]         cur_r;

  rhr_cordic_req_t creq;
  rhr_cordic_rsp_t crsp;

  rhr_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  // Fields of the entry just read.
  logic [31:0]     e_addr;
  logic signed [COORD_BITS-1:0] e_x, e_y;
  cw_t             dnx, dny;
  logic [31:0]     diff;
  logic [32:0]     rnd;
  logic [ANGLE_BITS-1:0] ang;
  logic            e_valid;

  always_comb begin
    e_addr  = rd_data_r[EW-1 -: 32];
    e_x     = rd_data_r[2*COORD_BITS-1 -: COORD_BITS];
    e_y     = rd_data_r[COORD_BITS-1:0];
    dnx     = CW'(e_x) - CW'($signed(sx_r));
    dny     = CW'(e_y) - CW'($signed(sy_r));
    e_valid = valid_r[idx_r[IW-1:0]];
    diff    = crsp.z - pref_r;
    rnd     = {1'b0, diff} + (33'd1 << (31 - ANGLE_BITS));
    ang     = rnd[31 -: ANGLE_BITS];
  end

  assign rd_addr = idx_r[IW-1:0];
  assign busy    = (state_r != S_IDLE);

  // CORDIC launches: previous-hop direction on start, entries during scan.
  always_comb begin
    creq.go = 1'b0;
    creq.x  = '0;
    creq.y  = '0;
    if (state_r == S_IDLE && start && in_op == OP_QUERY) begin
      creq.go = 1'b1;
      creq.x  = CW'(in_prev_x) - CW'(in_self_x);
      creq.y  = CW'(in_prev_y) - CW'(in_self_y);
    end else if (state_r == S_Q_CHK && e_valid && prev_ok_r &&
                 (dnx != '0 || dny != '0)) begin
      creq.go = 1'b1;
      creq.x  = dnx;
      creq.y  = dny;
    end
  end

  assign wr_en   = (state_r == S_WR_DONE) && (hit_r || free_r);
  assign wr_addr = hit_r ? hit_slot_r : free_slot_r;
  assign wr_data = {addr_r, nx_r, ny_r};

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            addr_r <= in_neighbor_addr;
            nx_r   <= in_neighbor_x;
            ny_r   <= in_neighbor_y;
            sx_r   <= in_self_x;
            sy_r   <= in_self_y;
            idx_r  <= '0;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
            any_r  <= 1'b0;
            found_r <= 1'b0;
            best_r <= {1'b1, {ANGLE_BITS{1'b0}}};
            best_addr_r <= '0;
            low_r  <= '0;
            prev_ok_r <= (in_prev_x != in_self_x) || (in_prev_y != in_self_y);
            if (in_op == OP_QUERY) begin
              state_r <= S_PREV_WAIT;
            end else if (in_op == OP_WRITE || in_op == OP_REMOVE) begin
              state_r <= S_SCAN_RD;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        // Address search for write and remove, one entry per read.
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (valid_r[idx_r[IW-1:0]] && e_addr == addr_r) begin
            if (!hit_r) begin
              hit_r      <= 1'b1;
              hit_slot_r <= idx_r[IW-1:0];
            end
            if (op_r == OP_REMOVE) begin
              valid_r[idx_r[IW-1:0]] <= 1'b0;
            end
          end
          if (!valid_r[idx_r[IW-1:0]] && !free_r) begin
            free_r      <= 1'b1;
            free_slot_r <= idx_r[IW-1:0];
          end
          if (idx_r == CT'(TABLE_DEPTH - 1)) begin
            state_r <= (op_r == OP_WRITE) ? S_WR_DONE : S_FINISH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_WR_DONE: begin
          if (hit_r) begin
            valid_r[hit_slot_r] <= 1'b1;
          end else if (free_r) begin
            valid_r[free_slot_r] <= 1'b1;
          end
          state_r <= S_FINISH;
        end
        S_PREV_WAIT: begin
          if (crsp.done) begin
            pref_r  <= crsp.z;
            state_r <= S_Q_RD;
          end
        end
        // Query scan: read an entry, then angle it in the CORDIC if needed.
        S_Q_RD: state_r <= S_Q_CHK;
        S_Q_CHK: begin
          cur_r <= idx_r[IW-1:0];
          if (e_valid) begin
            any_r <= 1'b1;
            if (!any_r || e_addr < low_r) begin
              low_r <= e_addr;
            end
          end
          if (creq.go) begin
            state_r <= S_Q_WAIT;
          end else if (idx_r == CT'(TABLE_DEPTH - 1)) begin
            state_r <= S_FINISH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_Q_RD;
          end
        end
        S_Q_WAIT: begin
          if (crsp.done) begin
            if (ang != '0 && ({1'b0, ang} < best_r ||
                ({1'b0, ang} == best_r && e_addr < best_addr_r))) begin
              best_r      <= {1'b0, ang};
              best_addr_r <= e_addr;
              found_r     <= 1'b1;
            end
            if (idx_r == CT'(TABLE_DEPTH - 1)) begin
              state_r <= S_FINISH;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_Q_RD;
            end
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          out_next_hop   <= '0;
          out_best_angle <= '0;
          out_status     <= ST_DONE;
          if (op_r == OP_WRITE && !hit_r && !free_r) begin
            out_status <= ST_FULL;
          end else if (op_r == OP_QUERY) begin
            if (!any_r) begin
              out_status <= ST_EMPTY;
            end else if (found_r) begin
              out_next_hop   <= best_addr_r;
              out_best_angle <= best_r[ANGLE_BITS-1:0];
              out_status     <= ST_ANGLE;
            end else begin
              out_next_hop <= low_r;
              out_status   <= ST_FALLBACK;
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result appears only after a busy period.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transaction");
  // The block is idle in the cycle a result is shown.
  a_idle_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while result shown");
  // A winning angle is never zero.
  a_angle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ANGLE) |-> out_best_angle != '0)
    else $error("zero winning angle");
  // Cursor latched for the entry under angle evaluation stays put.
  a_cur_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_WAIT && $past(state_r) == S_Q_WAIT) |-> $stable(cur_r))
    else $error("cursor moved during CORDIC");
endmodule

// ===== rtl/rhr_cordic.sv =====
module rhr_cordic (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rhr_pkg::rhr_cordic_req_t req,
  output rhr_pkg::rhr_cordic_rsp_t rsp
);
  import rhr_pkg::*;

  cw_t                 x_r, y_r, x_nxt, y_nxt;
  logic [31:0]         z_r, z_nxt;
  logic [STEP_BITS-1:0] i_r;
  logic                busy_r, done_r;
  cw_t                 xs, ys;

  // One vectoring step per cycle, arithmetic shifts by the step index.
  always_comb begin
    xs = cw_t'($signed(x_r) >>> i_r);
    ys = cw_t'($signed(y_r) >>> i_r);
    if ($signed(y_r) > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_turn(i_r);
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_turn(i_r);
    end
  end

  // Iteration control: load with the half-turn fold, then thirty steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        if (req.x[CW-1]) begin
          x_r <= -req.x;
          y_r <= -req.y;
          z_r <= 32'h80000000;
        end else begin
          x_r <= req.x;
          y_r <= req.y;
          z_r <= 32'h0;
        end
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 1'b1;
        if (i_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The angle register holds the final value while done is high.
  assign rsp.done = done_r;
  assign rsp.z    = z_r;
endmodule
